// ===== hdl/llcp_pkg.sv =====
`default_nettype none

package llcp_pkg;

	localparam int COORD_W    = 32;
	localparam int DIR_W      = 18;
	localparam int LEN_W      = 31;
	localparam int DIFF_W     = COORD_W + 1;
	localparam int CS_W       = 27;
	localparam int IN_DATA_W  = 184;
	localparam int OUT_DATA_W = 256;
	localparam int IN_DIR_LSB = 3 * COORD_W;
	localparam int IN_LEN_LSB = IN_DIR_LSB + 3 * DIR_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int QUEUE_DEPTH = 4;
	// Sign stage, setup stage, one stage per quotient bit, result stage.
	localparam int DIV_LAT    = COORD_W + 2;

	localparam logic [CFG_IDX_W-1:0] REG_A_ORG_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_A_ORG_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_A_ORG_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_A_DIR_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_A_DIR_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_A_DIR_Z = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_A_LEN   = 3'd6;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIR_W-1:0]   dir_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [CS_W-1:0]    cs_t;

	localparam dir_t DIR_ONE = 18'sd65536;

	typedef struct packed {
		coord_t [2:0]     pb;
		dir_t [2:0]       db;
		logic [LEN_W-1:0] lb;
		diff_t [2:0]      dd;
		cs_t [2:0]        c8;
		logic             par;
	} entry_t;

	function automatic dir_t clamp_dir(input logic [DIR_W-1:0] v);
		dir_t s;
		s = $signed(v);
		if (s > DIR_ONE) begin
			return DIR_ONE;
		end else if (s < -DIR_ONE) begin
			return -DIR_ONE;
		end else begin
			return s;
		end
	endfunction

endpackage

`default_nettype wire

// ===== hdl/llcp_div.sv =====
`default_nettype none

module llcp_div #(
	parameter int NW = 62,
	parameter int DW = 52,
	parameter int FB = 24
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic [NW-1:0]                       num,
	input  logic [DW-1:0]                       den,
	output logic signed [llcp_pkg::COORD_W-1:0] quo
);
	import llcp_pkg::*;

	localparam int STEPS = COORD_W - 1;
	localparam int SH    = STEPS - FB;
	localparam int CW    = NW + DW + COORD_W;

	logic          neg_s0;
	logic [NW-1:0] mag_s0;
	logic [DW-1:0] den_s0;

	logic [DW-1:0]    rem [STEPS];
	logic [DW-1:0]    dv  [STEPS];
	logic [SH-1:0]    lo  [STEPS];
	logic [STEPS-1:0] qt  [STEPS+1];
	logic             ng  [STEPS+1];
	logic             st  [STEPS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s0 <= num[NW-1];
			mag_s0 <= num[NW-1] ? NW'(-num) : num;
			den_s0 <= den;
		end
	end

	// The quotient saturates when it would need more than the integer bits left.
	always_ff @(posedge clk) begin
		if (en) begin
			st[0]  <= CW'(mag_s0) >= (CW'(den_s0) << SH);
			rem[0] <= DW'(CW'(mag_s0) >> SH);
			lo[0]  <= mag_s0[SH-1:0];
			dv[0]  <= den_s0;
			ng[0]  <= neg_s0;
			qt[0]  <= '0;
		end
	end

	for (genvar j = 0; j < STEPS; j++) begin : g_step
		localparam int K = STEPS - 1 - j;
		logic          nb;
		logic [DW:0]   tr;
		logic [DW:0]   df;
		logic          ge;

		if (K >= FB) begin : g_bit
			assign nb = lo[j][K-FB];
		end else begin : g_zero
			assign nb = 1'b0;
		end

		assign tr = {rem[j], nb};
		assign df = tr - {1'b0, dv[j]};
		assign ge = tr >= {1'b0, dv[j]};

		always_ff @(posedge clk) begin
			if (en) begin
				qt[j+1] <= {qt[j][STEPS-2:0], ge};
				ng[j+1] <= ng[j];
				st[j+1] <= st[j];
			end
		end

		if (j < STEPS - 1) begin : g_pass
			always_ff @(posedge clk) begin
				if (en) begin
					rem[j+1] <= ge ? df[DW-1:0] : tr[DW-1:0];
					dv[j+1]  <= dv[j];
					lo[j+1]  <= lo[j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (st[STEPS]) begin
				quo <= ng[STEPS] ? {1'b1, {STEPS{1'b0}}} : {1'b0, {STEPS{1'b1}}};
			end else if (ng[STEPS]) begin
				quo <= -$signed({1'b0, qt[STEPS]});
			end else begin
				quo <= $signed({1'b0, qt[STEPS]});
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/llcp_front.sv =====
`default_nettype none

module llcp_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [llcp_pkg::IN_DATA_W-1:0]    s_tdata,
	input  llcp_pkg::coord_t [2:0]            pa,
	input  llcp_pkg::dir_t [2:0]              da,
	input  logic                              full,
	output logic                              push,
	output llcp_pkg::entry_t                  entry
);
	import llcp_pkg::*;

	logic                 v_q;
	logic [IN_DATA_W-1:0] data_q;
	logic signed [35:0]   m [6];
	logic [35:0]          cr [3];
	logic [35:0]          ca [3];

	assign push     = v_q && !full;
	assign s_tready = !v_q || !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (s_tready) begin
			v_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_q <= s_tdata;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			entry.pb[i] = data_q[i*COORD_W +: COORD_W];
			entry.db[i] = clamp_dir(data_q[IN_DIR_LSB + i*DIR_W +: DIR_W]);
			entry.dd[i] = $signed({entry.pb[i][COORD_W-1], entry.pb[i]})
				- $signed({pa[i][COORD_W-1], pa[i]});
		end
		entry.lb = data_q[IN_LEN_LSB +: LEN_W];

		m[0] = $signed(da[1]) * $signed(entry.db[2]);
		m[1] = $signed(da[2]) * $signed(entry.db[1]);
		m[2] = $signed(da[2]) * $signed(entry.db[0]);
		m[3] = $signed(da[0]) * $signed(entry.db[2]);
		m[4] = $signed(da[0]) * $signed(entry.db[1]);
		m[5] = $signed(da[1]) * $signed(entry.db[0]);

		// Scale the direction cross product down by 256, rounding toward zero.
		for (int i = 0; i < 3; i++) begin
			cr[i] = m[2*i] - m[2*i+1];
			ca[i] = cr[i] + {28'd0, {8{cr[i][35]}}};
			entry.c8[i] = ca[i][8 +: CS_W];
		end
		entry.par = (entry.c8[0] == '0) && (entry.c8[1] == '0) && (entry.c8[2] == '0);
	end

endmodule

`default_nettype wire

// ===== hdl/llcp_fifo.sv =====
`default_nettype none

module llcp_fifo #(
	parameter int DEPTH = llcp_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  llcp_pkg::entry_t wdata,
	output logic             full,
	input  logic             pop,
	output llcp_pkg::entry_t rdata,
	output logic             empty
);
	import llcp_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t        slot_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full  = cnt_q == CW'(DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10: begin
					cnt_q <= cnt_q + 1'b1;
				end
				2'b01: begin
					cnt_q <= cnt_q - 1'b1;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/llcp_back.sv =====
`default_nettype none

module llcp_back (
	input  logic                              clk,
	input  logic                              arst_n,
	output logic                              pop,
	input  logic                              empty,
	input  llcp_pkg::entry_t                  entry,
	input  llcp_pkg::coord_t [2:0]            pa,
	input  llcp_pkg::dir_t [2:0]              da,
	input  logic [llcp_pkg::LEN_W-1:0]        la,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [llcp_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                              m_tuser
);
	import llcp_pkg::*;

	// Four setup stages, two dividers in a row and one output stage; the product
	// stage runs beside the first stage of the second divider pair.
	localparam int NL = 2 * DIV_LAT + 5;

	typedef struct packed {
		coord_t [2:0]     pb;
		dir_t [2:0]       db;
		logic [LEN_W-1:0] lb;
		logic             par;
	} side_t;

	typedef struct packed {
		logic [2:0][COORD_W-1:0] na;
		logic [2:0][COORD_W-1:0] nb;
		logic [LEN_W-1:0]        lb;
		logic                    par;
	} tail_t;

	function automatic logic [COORD_W-1:0] sat32(input logic [34:0] v);
		if (!v[34] && (v[33:31] != 3'b000)) begin
			return {1'b0, {(COORD_W-1){1'b1}}};
		end else if (v[34] && (v[33:31] != 3'b111)) begin
			return {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			return v[COORD_W-1:0];
		end
	endfunction

	logic          en;
	logic [NL-1:0] vld_q;

	logic signed [50:0] pdb_s1 [6];
	logic signed [50:0] pda_s1 [6];
	logic [50:0]        csq_s1 [3];
	cs_t                c8_s1 [3];
	side_t              sd_s1;
	logic signed [53:0] sq [3];

	logic [51:0]        dfb [3];
	logic [51:0]        dfa [3];
	logic [51:0]        ajb [3];
	logic [51:0]        aja [3];
	logic signed [34:0] eb_s2 [3];
	logic signed [34:0] ea_s2 [3];
	logic [51:0]        den_s2;
	cs_t                c8_s2 [3];
	side_t              sd_s2;

	logic signed [61:0] nb_s3 [3];
	logic signed [61:0] na_s3 [3];
	logic [51:0]        den_s3;
	side_t              sd_s3;

	logic signed [61:0] numa_s4;
	logic signed [61:0] numb_s4;
	logic [51:0]        den_s4;
	side_t              sd_s4;

	side_t              sd_d [DIV_LAT];
	side_t              sd38;
	logic signed [COORD_W-1:0] ta38;
	logic signed [COORD_W-1:0] tb38;

	logic signed [49:0] pra_s39 [3];
	logic signed [49:0] prb_s39 [3];
	coord_t [2:0]       pb_s39;
	logic [LEN_W-1:0]   lb_s39;
	logic               par_s39;

	logic [49:0]        aja4 [3];
	logic [49:0]        ajb4 [3];
	tail_t              tl40;
	tail_t              tl_d [DIV_LAT-1];
	tail_t              tl72;
	logic signed [COORD_W-1:0] fa72;
	logic signed [COORD_W-1:0] fb72;

	logic [OUT_DATA_W-1:0] data_s73;
	logic                  found_s73;

	assign en       = !vld_q[NL-1] || m_tready;
	assign pop      = en && !empty;
	assign m_tvalid = vld_q[NL-1];
	assign m_tdata  = data_s73;
	assign m_tuser  = found_s73;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NL-2:0], pop};
		end
	end

	// Stage 1: cross products with the origin difference, squared scaled normal.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sq[i] = $signed(entry.c8[i]) * $signed(entry.c8[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pdb_s1[0] <= $signed(entry.dd[1]) * $signed(entry.db[2]);
			pdb_s1[1] <= $signed(entry.dd[2]) * $signed(entry.db[1]);
			pdb_s1[2] <= $signed(entry.dd[2]) * $signed(entry.db[0]);
			pdb_s1[3] <= $signed(entry.dd[0]) * $signed(entry.db[2]);
			pdb_s1[4] <= $signed(entry.dd[0]) * $signed(entry.db[1]);
			pdb_s1[5] <= $signed(entry.dd[1]) * $signed(entry.db[0]);
			pda_s1[0] <= $signed(entry.dd[1]) * $signed(da[2]);
			pda_s1[1] <= $signed(entry.dd[2]) * $signed(da[1]);
			pda_s1[2] <= $signed(entry.dd[2]) * $signed(da[0]);
			pda_s1[3] <= $signed(entry.dd[0]) * $signed(da[2]);
			pda_s1[4] <= $signed(entry.dd[0]) * $signed(da[1]);
			pda_s1[5] <= $signed(entry.dd[1]) * $signed(da[0]);
			for (int i = 0; i < 3; i++) begin
				csq_s1[i] <= sq[i][50:0];
				c8_s1[i]  <= entry.c8[i];
			end
			sd_s1 <= '{pb: entry.pb, db: entry.db, lb: entry.lb, par: entry.par};
		end
	end

	// Stage 2: finish the cross products and drop them to Q16.16 toward zero.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dfb[i] = {pdb_s1[2*i][50], pdb_s1[2*i]} - {pdb_s1[2*i+1][50], pdb_s1[2*i+1]};
			dfa[i] = {pda_s1[2*i][50], pda_s1[2*i]} - {pda_s1[2*i+1][50], pda_s1[2*i+1]};
			ajb[i] = dfb[i] + {36'd0, {16{dfb[i][51]}}};
			aja[i] = dfa[i] + {36'd0, {16{dfa[i][51]}}};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				eb_s2[i] <= ajb[i][16 +: 35];
				ea_s2[i] <= aja[i][16 +: 35];
				c8_s2[i] <= c8_s1[i];
			end
			den_s2 <= {1'b0, csq_s1[0]} + {1'b0, csq_s1[1]} + {1'b0, csq_s1[2]};
			sd_s2  <= sd_s1;
		end
	end

	// Stage 3: dot-product terms.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				nb_s3[i] <= eb_s2[i] * c8_s2[i];
				na_s3[i] <= ea_s2[i] * c8_s2[i];
			end
			den_s3 <= den_s2;
			sd_s3  <= sd_s2;
		end
	end

	// Stage 4: dot-product sums; the term from D x Db gives the parameter on line A.
	always_ff @(posedge clk) begin
		if (en) begin
			numa_s4 <= nb_s3[0] + nb_s3[1] + nb_s3[2];
			numb_s4 <= na_s3[0] + na_s3[1] + na_s3[2];
			den_s4  <= den_s3;
			sd_s4   <= sd_s3;
		end
	end

	llcp_div #(.NW(62), .DW(52), .FB(24)) u_div_ta (
		.clk (clk),
		.en  (en),
		.num (numa_s4),
		.den (den_s4),
		.quo (ta38)
	);

	llcp_div #(.NW(62), .DW(52), .FB(24)) u_div_tb (
		.clk (clk),
		.en  (en),
		.num (numb_s4),
		.den (den_s4),
		.quo (tb38)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sd_d[0] <= sd_s4;
			for (int i = 1; i < DIV_LAT; i++) begin
				sd_d[i] <= sd_d[i-1];
			end
		end
	end
	assign sd38 = sd_d[DIV_LAT-1];

	// Direction times parameter, then the offset from each origin.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pra_s39[i] <= $signed(da[i]) * ta38;
				prb_s39[i] <= $signed(sd38.db[i]) * tb38;
			end
			pb_s39  <= sd38.pb;
			lb_s39  <= sd38.lb;
			par_s39 <= sd38.par;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			aja4[i] = pra_s39[i] + {34'd0, {16{pra_s39[i][49]}}};
			ajb4[i] = prb_s39[i] + {34'd0, {16{prb_s39[i][49]}}};
			tl40.na[i] = sat32({{3{pa[i][COORD_W-1]}}, pa[i]}
				+ {aja4[i][49], aja4[i][49:16]});
			tl40.nb[i] = sat32({{3{pb_s39[i][COORD_W-1]}}, pb_s39[i]}
				+ {ajb4[i][49], ajb4[i][49:16]});
		end
		tl40.lb  = lb_s39;
		tl40.par = par_s39;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tl_d[0] <= tl40;
			for (int i = 1; i < DIV_LAT - 1; i++) begin
				tl_d[i] <= tl_d[i-1];
			end
		end
	end
	assign tl72 = tl_d[DIV_LAT-2];

	llcp_div #(.NW(COORD_W), .DW(LEN_W), .FB(16)) u_div_fa (
		.clk (clk),
		.en  (en),
		.num (ta38),
		.den (la),
		.quo (fa72)
	);

	llcp_div #(.NW(COORD_W), .DW(LEN_W), .FB(16)) u_div_fb (
		.clk (clk),
		.en  (en),
		.num (tb38),
		.den (sd38.lb),
		.quo (fb72)
	);

	// Parallel lines give an all-zero result; a zero length gives a zero fraction.
	always_ff @(posedge clk) begin
		if (en) begin
			if (tl72.par) begin
				data_s73  <= '0;
				found_s73 <= 1'b0;
			end else begin
				data_s73  <= {(tl72.lb == '0) ? '0 : fb72, tl72.nb[2], tl72.nb[1], tl72.nb[0],
					(la == '0) ? '0 : fa72, tl72.na[2], tl72.na[1], tl72.na[0]};
				found_s73 <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/line_line_closest_points_unit.sv =====
`default_nettype none
// Throughput: one request per cycle while the output is not stalled; the two quotient stages,
// each one bit per pipeline stage in a 34-stage restoring divider, set the depth but never the rate.
// Reset clears the handshake state, the queue and the line A registers (origin 0,
// direction +x, length 1.0). No clearing pass follows reset.

module line_line_closest_points_unit #(
	parameter int QDEPTH = llcp_pkg::QUEUE_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [llcp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [llcp_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// b_origin_x, b_origin_y, b_origin_z, b_dir_x, b_dir_y, b_dir_z, b_length, zero pad
	input  logic [llcp_pkg::IN_DATA_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// near_a_x, near_a_y, near_a_z, frac_a, near_b_x, near_b_y, near_b_z, frac_b
	output logic [llcp_pkg::OUT_DATA_W-1:0]    m_tdata,
	// found
	output logic                               m_tuser
);
	import llcp_pkg::*;

	coord_t [2:0]           pa_q;
	logic [2:0][DIR_W-1:0]  da_q;
	logic [LEN_W-1:0]       la_q;
	dir_t [2:0]             da_c;

	logic   push;
	logic   pop;
	logic   full;
	logic   empty;
	entry_t qin;
	entry_t qout;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pa_q[0] <= '0;
			pa_q[1] <= '0;
			pa_q[2] <= '0;
			da_q[0] <= DIR_ONE;
			da_q[1] <= '0;
			da_q[2] <= '0;
			la_q    <= LEN_W'(65536);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_A_ORG_X: begin
					pa_q[0] <= cfg_data;
				end
				REG_A_ORG_Y: begin
					pa_q[1] <= cfg_data;
				end
				REG_A_ORG_Z: begin
					pa_q[2] <= cfg_data;
				end
				REG_A_DIR_X: begin
					da_q[0] <= cfg_data[DIR_W-1:0];
				end
				REG_A_DIR_Y: begin
					da_q[1] <= cfg_data[DIR_W-1:0];
				end
				REG_A_DIR_Z: begin
					da_q[2] <= cfg_data[DIR_W-1:0];
				end
				REG_A_LEN: begin
					la_q <= cfg_data[LEN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			da_c[i] = clamp_dir(da_q[i]);
		end
	end

	llcp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.pa       (pa_q),
		.da       (da_c),
		.full     (full),
		.push     (push),
		.entry    (qin)
	);

	llcp_fifo #(.DEPTH(QDEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (qin),
		.full   (full),
		.pop    (pop),
		.rdata  (qout),
		.empty  (empty)
	);

	llcp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop      (pop),
		.empty    (empty),
		.entry    (qout),
		.pa       (pa_q),
		.da       (da_c),
		.la       (la_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire
